/* design/rgbd_pkg.sv */
// shared types and constants for the rgb button dimmer
`default_nettype none

package rgbd_pkg;

  localparam int unsigned LevelWidth = 8;
  localparam int unsigned HoldWidth  = 10;
  localparam int unsigned CfgWidth   = 10;
  localparam int unsigned CfgIdxWidth = 2;

  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [HoldWidth-1:0]  hold_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_BLUE  = 2'd3
  } mode_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } rgb_t;

  localparam logic       OP_BUTTON = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  // active-low pin patterns with one button pressed
  localparam logic [2:0] BTN_MODE_ONLY = 3'd5;
  localparam logic [2:0] BTN_UP_ONLY   = 3'd6;
  localparam logic [2:0] BTN_DOWN_ONLY = 3'd3;

  localparam logic [CfgIdxWidth-1:0] REG_HOLD_TICKS     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_BASE_STEP      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_STEP_INCREMENT = 2'd2;

  localparam hold_t  HOLD_TICKS_RESET     = 10'd305;
  localparam level_t BASE_STEP_RESET      = 8'd5;
  localparam level_t STEP_INCREMENT_RESET = 8'd5;
  localparam level_t LEVEL_MAX            = 8'd255;

endpackage

`default_nettype wire

/* design/rgbd_level.sv */
// saturating up/down move of the selected color channel
`default_nettype none

module rgbd_level (
  input  var rgbd_pkg::mode_t  mode,
  input  var rgbd_pkg::rgb_t   levels,
  input  var logic             up,
  input  var rgbd_pkg::level_t step,
  output rgbd_pkg::rgb_t       levels_next
);
  import rgbd_pkg::*;

  level_t         cur;
  level_t         moved;
  logic [LevelWidth:0] sum;

  always_comb begin
    unique case (mode)
      MODE_RED:   cur = levels.red;
      MODE_GREEN: cur = levels.green;
      MODE_BLUE:  cur = levels.blue;
      default:    cur = levels.red;
    endcase
  end

  assign sum = {1'b0, cur} + {1'b0, step};

  always_comb begin
    if (up) begin
      if (sum >= {1'b0, LEVEL_MAX}) begin
        moved = LEVEL_MAX;
      end else begin
        moved = sum[LevelWidth-1:0];
      end
    end else begin
      if (cur <= step) begin
        moved = '0;
      end else begin
        moved = cur - step;
      end
    end
  end

  always_comb begin
    levels_next = levels;
    unique case (mode)
      MODE_RED:   levels_next.red   = moved;
      MODE_GREEN: levels_next.green = moved;
      MODE_BLUE:  levels_next.blue  = moved;
      default:    levels_next = levels;
    endcase
  end

endmodule

`default_nettype wire

/* design/rgb_button_dimmer.sv */
// top level of the rgb button dimmer
`default_nettype none

// Three-button RGB level controller. Each input item is a button pin change
// (op 0) or a timer tick (op 1) carrying the active-low pins (bit0 up, bit1
// mode, bit2 down), and gives one result item with the mode, the three 8-bit
// levels and the repeat flag after the update. An item is registered on
// acceptance, and its update is applied in a single step of logic when it
// leaves the input register; a new item can be taken every cycle while the
// result is taken, so the block runs at one item per cycle unless the result
// is held. Each result shows once its update is applied. The state registers
// double as the result register, and they only move when the result slot is
// free or being taken. Configuration: index 0 hold_ticks, 1 base_step,
// 2 step_increment; other indexes are ignored.

module rgb_button_dimmer (
  input  var logic                             clk,
  input  var logic                             rst,
  input  var logic                             in_valid,
  output logic                                 in_ready,
  input  var logic                             op,
  input  var logic [2:0]                       buttons,
  output logic                                 out_valid,
  input  var logic                             out_ready,
  output logic [1:0]                           mode,
  output logic [7:0]                           red_level,
  output logic [7:0]                           green_level,
  output logic [7:0]                           blue_level,
  output logic                                 repeat_armed,
  input  var logic                             cfg_we,
  input  var logic [rgbd_pkg::CfgIdxWidth-1:0] cfg_index,
  input  var logic [rgbd_pkg::CfgWidth-1:0]    cfg_data
);
  import rgbd_pkg::*;

  hold_t  hold_ticks;
  level_t base_step;
  level_t step_increment;

  logic       item_valid;
  logic       item_op;
  logic [2:0] item_buttons;
  logic       advance;

  mode_t  mode_reg, mode_next;
  rgb_t   levels, levels_next, moved;
  level_t step_size, step_next;
  hold_t  hold_count, hold_next, hold_inc;
  logic   armed, armed_next;
  logic   do_adjust;
  logic   adj_up;
  logic   single_updown;
  logic [LevelWidth:0] step_sum;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks     <= HOLD_TICKS_RESET;
      base_step      <= BASE_STEP_RESET;
      step_increment <= STEP_INCREMENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_TICKS:     hold_ticks     <= cfg_data;
        REG_BASE_STEP:      base_step      <= cfg_data[LevelWidth-1:0];
        REG_STEP_INCREMENT: step_increment <= cfg_data[LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op      <= op;
      item_buttons <= buttons;
    end
  end

  assign single_updown = (item_buttons == BTN_UP_ONLY) || (item_buttons == BTN_DOWN_ONLY);
  assign adj_up        = (item_buttons == BTN_UP_ONLY);
  assign hold_inc      = hold_count + hold_t'(1);
  assign step_sum      = {1'b0, step_size} + {1'b0, step_increment};

  always_comb begin
    mode_next  = mode_reg;
    step_next  = step_size;
    hold_next  = hold_count;
    armed_next = armed;
    do_adjust  = 1'b0;
    if (item_op == OP_BUTTON) begin
      armed_next = 1'b0;
      hold_next  = '0;
      step_next  = base_step;
      if (item_buttons == BTN_MODE_ONLY) begin
        mode_next = mode_t'(mode_reg + 2'd1);
      end else if (single_updown) begin
        do_adjust  = 1'b1;
        armed_next = (mode_reg != MODE_IDLE);
      end
    end else if (armed) begin
      if (hold_inc >= hold_ticks) begin
        hold_next = '0;
        if (step_sum > {1'b0, LEVEL_MAX}) begin
          step_next = LEVEL_MAX;
        end else begin
          step_next = step_sum[LevelWidth-1:0];
        end
        do_adjust = single_updown;
      end else begin
        hold_next = hold_inc;
      end
    end
  end

  rgbd_level u_level (
    .mode        (mode_reg),
    .levels      (levels),
    .up          (adj_up),
    .step        (step_next),
    .levels_next (moved)
  );

  assign levels_next = do_adjust ? moved : levels;

  // state registers, also the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      mode_reg   <= MODE_IDLE;
      levels     <= '0;
      step_size  <= BASE_STEP_RESET;
      hold_count <= '0;
      armed      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        mode_reg   <= mode_next;
        levels     <= levels_next;
        step_size  <= step_next;
        hold_count <= hold_next;
        armed      <= armed_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign mode         = mode_reg;
  assign red_level    = levels.red;
  assign green_level  = levels.green;
  assign blue_level   = levels.blue;
  assign repeat_armed = armed;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// testbench for the rgb button dimmer: predicted mode, levels and repeat flag checked per item
module tb_top;
  import rgbd_pkg::*;

  localparam int QuietLimit = 500;
  localparam logic [2:0] BTN_NONE = 3'b111;
  localparam logic [CfgIdxWidth-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    mode_t  mode;
    level_t red;
    level_t green;
    level_t blue;
    logic   armed;
  } led_state_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_BUTTON;
  logic [2:0]             buttons = BTN_NONE;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             mode;
  logic [7:0]             red_level;
  logic [7:0]             green_level;
  logic [7:0]             blue_level;
  logic                   repeat_armed;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = REG_HOLD_TICKS;
  logic [CfgWidth-1:0]    cfg_data = '0;

  hold_t  hold_ticks_r = HOLD_TICKS_RESET;
  level_t base_step_r = BASE_STEP_RESET;
  level_t step_inc_r = STEP_INCREMENT_RESET;

  mode_t  sel_mode = MODE_IDLE;
  level_t red_r = '0;
  level_t green_r = '0;
  level_t blue_r = '0;
  level_t step_r = BASE_STEP_RESET;
  hold_t  hold_cnt = '0;
  logic   armed_r = 1'b0;

  led_state_t pending_levels[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  rgb_button_dimmer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .buttons(buttons),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mode(mode),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level),
    .repeat_armed(repeat_armed),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic level_t nudge(level_t lv, logic up, level_t st);
    logic [8:0] total;
    total = {1'b0, lv} + {1'b0, st};
    if (up) return (total >= 9'(LEVEL_MAX)) ? LEVEL_MAX : total[7:0];
    return (lv <= st) ? 8'd0 : lv - st;
  endfunction

  function automatic logic adjust_channel(logic up);
    case (sel_mode)
      MODE_RED: red_r = nudge(red_r, up, step_r);
      MODE_GREEN: green_r = nudge(green_r, up, step_r);
      MODE_BLUE: blue_r = nudge(blue_r, up, step_r);
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic led_state_t advance_dimmer(logic kind, logic [2:0] pins);
    logic [8:0] grown;
    if (kind == OP_BUTTON) begin
      armed_r = 1'b0;
      hold_cnt = '0;
      step_r = base_step_r;
      if (pins == BTN_MODE_ONLY) begin
        sel_mode = mode_t'(2'(sel_mode + 2'd1));
      end else if (pins == BTN_UP_ONLY || pins == BTN_DOWN_ONLY) begin
        armed_r = adjust_channel(pins == BTN_UP_ONLY);
      end
    end else if (armed_r) begin
      hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt >= hold_ticks_r) begin
        hold_cnt = '0;
        grown = {1'b0, step_r} + {1'b0, step_inc_r};
        step_r = (grown > 9'(LEVEL_MAX)) ? LEVEL_MAX : grown[7:0];
        if (pins == BTN_UP_ONLY || pins == BTN_DOWN_ONLY) begin
          void'(adjust_channel(pins == BTN_UP_ONLY));
        end
      end
    end
    return '{mode: sel_mode, red: red_r, green: green_r, blue: blue_r, armed: armed_r};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    led_state_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
      end else begin
        want = pending_levels.pop_front();
        check_field("mode", 8'(want.mode), 8'(mode));
        check_field("red_level", want.red, red_level);
        check_field("green_level", want.green, green_level);
        check_field("blue_level", want.blue, blue_level);
        check_field("repeat_armed", 8'(want.armed), 8'(repeat_armed));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic kind, logic [2:0] pins);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    buttons <= pins;
    do @(posedge clk); while (!in_ready);
    pending_levels.push_back(advance_dimmer(kind, pins));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HOLD_TICKS: hold_ticks_r = value;
      REG_BASE_STEP: base_step_r = value[7:0];
      REG_STEP_INCREMENT: step_inc_r = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned hold, int unsigned base, int unsigned incr);
    settle();
    write_reg(REG_HOLD_TICKS, hold_t'(hold));
    write_reg(REG_BASE_STEP, {2'($urandom), 8'(base)});
    write_reg(REG_STEP_INCREMENT, {2'($urandom), 8'(incr)});
  endtask

  task automatic select_mode(mode_t target);
    while (sel_mode != target) send_item(OP_BUTTON, BTN_MODE_ONLY);
  endtask

  task automatic run_random(int count);
    int sent;
    int ticks;
    logic [2:0] press;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          press = $urandom_range(0, 1) ? BTN_UP_ONLY : BTN_DOWN_ONLY;
          ticks = $urandom_range(1, 12);
          send_item(OP_BUTTON, press);
          repeat (ticks) begin
            send_item(OP_TICK, ($urandom_range(0, 9) == 0) ? 3'($urandom) : press);
          end
          send_item(OP_BUTTON, ($urandom_range(0, 3) == 0) ? 3'($urandom) : BTN_NONE);
          sent += ticks + 2;
        end
        6, 7: begin
          send_item(OP_BUTTON, BTN_MODE_ONLY);
          send_item(OP_BUTTON, BTN_NONE);
          sent += 2;
        end
        default: begin
          send_item(1'($urandom), 3'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_basic_buttons();
    send_item(OP_TICK, BTN_NONE);
    send_item(OP_BUTTON, BTN_UP_ONLY);
    send_item(OP_BUTTON, BTN_DOWN_ONLY);
    send_item(OP_BUTTON, 3'b000);
    send_item(OP_BUTTON, BTN_MODE_ONLY);
    send_item(OP_BUTTON, BTN_UP_ONLY);
    send_item(OP_TICK, BTN_UP_ONLY);
    send_item(OP_BUTTON, 3'b010);
    send_item(OP_BUTTON, BTN_DOWN_ONLY);
    send_item(OP_BUTTON, 3'b100);
    send_item(OP_BUTTON, 3'b001);
    send_item(OP_BUTTON, BTN_MODE_ONLY);
    send_item(OP_BUTTON, BTN_UP_ONLY);
    send_item(OP_BUTTON, BTN_MODE_ONLY);
    send_item(OP_BUTTON, BTN_DOWN_ONLY);
    send_item(OP_BUTTON, BTN_MODE_ONLY);
  endtask

  task automatic test_repeat_extremes();
    set_config(1, 255, 255);
    select_mode(MODE_RED);
    send_item(OP_BUTTON, BTN_UP_ONLY);
    send_item(OP_TICK, BTN_UP_ONLY);
    send_item(OP_BUTTON, BTN_DOWN_ONLY);
    send_item(OP_TICK, BTN_DOWN_ONLY);
    send_item(OP_TICK, BTN_NONE);
    set_config(0, 0, 0);
    write_reg(REG_NONE, CfgWidth'($urandom));
    send_item(OP_BUTTON, BTN_UP_ONLY);
    send_item(OP_TICK, BTN_UP_ONLY);
    send_item(OP_TICK, BTN_UP_ONLY);
  endtask

  task automatic test_long_hold();
    set_config(200, 1, 2);
    select_mode(MODE_GREEN);
    send_item(OP_BUTTON, BTN_UP_ONLY);
    repeat (205) send_item(OP_TICK, BTN_UP_ONLY);
    send_item(OP_BUTTON, BTN_NONE);
  endtask

  task automatic test_random_settings();
    set_config(1, 1, 0);
    run_random(80);
    set_config(3, 255, 255);
    run_random(80);
    set_config(2, 0, 1);
    run_random(80);
    set_config(0, 17, 9);
    run_random(80);
    set_config($urandom_range(1, 6), $urandom_range(1, 255), $urandom_range(0, 255));
    run_random(80);
  endtask

  task automatic test_final_burst();
    idle_on = 1'b0;
    set_config($urandom_range(1, 8), $urandom_range(1, 255), $urandom_range(0, 255));
    run_random(100);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_basic_buttons();
    test_repeat_extremes();
    test_long_hold();
    test_random_settings();
    test_final_burst();
    settle();
    repeat (10) @(posedge clk);
    if (pending_levels.size() != 0) begin
      $error("%0d predicted items never came out", pending_levels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
